@@ rtl/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

	// field widths
	localparam int IDX_W  = 8;
	localparam int BC_W   = 9;
	localparam int BB_W   = 13;
	localparam int OFS_W  = 20;
	localparam int CFG_W  = 13;
	localparam int OUT_W  = 32;

	// register indexes on the configuration port
	localparam logic REG_BLOCK_COUNT = 1'b0;
	localparam logic REG_BLOCK_BYTES = 1'b1;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} st_t;

	// access request from the control to the link store
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] wr_data;
		logic             clear;
	} link_req_t;

endpackage

@@ rtl/fbfl_ram.sv @@
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/fbfl_link_store.sv @@
// ----------------------------------------------------------------------------
// fbfl_link_store
// Next-link store: RAM plus one written flag per entry. An entry not written
// since the last rechain reads as its own index plus one (fresh chain).
// ----------------------------------------------------------------------------
module fbfl_link_store #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fbfl_pkg::link_req_t      req,
	output logic [fbfl_pkg::IDX_W-1:0] link
);
	import fbfl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [DEPTH-1:0] vld_q;
	logic             rvld_s1;
	logic [IDX_W-1:0] raddr_s1;
	logic [IDX_W-1:0] rdata;

	fbfl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr[AW-1:0]),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr[AW-1:0]),
		.rdata (rdata)
	);

	// track written entries; rechain drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr[AW-1:0]] <= 1'b1;
		end
	end

	// hold the flag and address of the read alongside the RAM output
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rvld_s1  <= vld_q[req.rd_addr[AW-1:0]];
			raddr_s1 <= req.rd_addr;
		end
	end

	// fresh entries link to the next index
	assign link = rvld_s1 ? rdata : raddr_s1 + IDX_W'(1);

endmodule

@@ rtl/fixed_block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// One bucket of equal-sized blocks on a LIFO free list (link store + head).
// The result is registered in ST_EXEC, the state after the item is accepted.
// A new item is taken only in ST_IDLE with the output register free, so
// it waits while ST_EXEC uses the head's next link read from the link RAM.
// Reset: block_count 256, block_bytes 16, fresh chain from index 0; the
// chain is restored at once by clearing per-entry written flags, no sweep.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] block_index
	input  logic                         s_tuser,  // [0] req_type
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fbfl_pkg::OUT_W-1:0]   m_tdata,  // [0] granted, [8:1] given_index,
	                                               // [28:9] given_offset,
	                                               // [29] exhausted,
	                                               // [30] bucket_released, [31] zero
	// configuration
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [fbfl_pkg::CFG_W-1:0]   cfg_data
);
	import fbfl_pkg::*;

	localparam int LIM   = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
	localparam int DEPTH = LIM;

	st_t              state_q, state_d;
	logic [BC_W-1:0]  block_count_q;
	logic [BB_W-1:0]  block_bytes_q;
	logic [IDX_W-1:0] head_q;
	logic             head_valid_q;
	logic [BC_W-1:0]  fc_q;

	logic             req_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             m_valid_q;
	logic             granted_q;
	logic [IDX_W-1:0] given_index_q;
	logic [OFS_W-1:0] given_offset_q;
	logic             exhausted_q;
	logic             released_q;

	logic             accept;
	logic             exec;
	link_req_t        lreq;
	logic [IDX_W-1:0] link;

	logic [BC_W-1:0]      ec;
	logic                 alloc_ok;
	logic [IDX_W+BB_W-1:0] prod;
	logic [BC_W-1:0]      fc_inc;
	logic                 free_ok;
	logic                 release_hit;
	logic [BC_W-1:0]      cfg_count;
	logic [BC_W-1:0]      cfg_ec;

	// clamp a block count into 1..LIM
	function automatic logic [BC_W-1:0] eff_count(input logic [BC_W-1:0] bc);
		logic [BC_W-1:0] c;
		c = bc;
		if (c == '0) begin
			c = BC_W'(1);
		end
		if (c > BC_W'(LIM)) begin
			c = BC_W'(LIM);
		end
		return c;
	endfunction

	fbfl_link_store #(
		.DEPTH (DEPTH)
	) u_links (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.link   (link)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		exec     = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = !m_valid_q || m_tready;
			ST_EXEC: exec = 1'b1;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// request datapath
	assign ec          = eff_count(block_count_q);
	assign alloc_ok    = head_valid_q && (fc_q != '0);
	assign prod        = head_q * block_bytes_q;
	assign free_ok     = {1'b0, idx_s1} < ec;
	assign fc_inc      = (fc_q < ec) ? fc_q + BC_W'(1) : fc_q;
	assign release_hit = (req_s1 == REQ_FREE) && free_ok && (fc_inc >= ec);
	assign cfg_count   = (cfg_index == REG_BLOCK_COUNT) ? cfg_data[BC_W-1:0] : block_count_q;
	assign cfg_ec      = eff_count(cfg_count);

	// link store accesses: read the head's link on an accepted allocate, push on a free
	always_comb begin
		lreq.rd_en   = accept && (s_tuser == REQ_ALLOC);
		lreq.rd_addr = head_q;
		lreq.wr_en   = exec && (req_s1 == REQ_FREE) && free_ok;
		lreq.wr_addr = idx_s1;
		lreq.wr_data = head_valid_q ? head_q : '0;
		lreq.clear   = cfg_we || (exec && release_hit);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= s_tuser;
			idx_s1 <= s_tdata;
		end
	end

	// configuration and list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BC_W'(256);
			block_bytes_q <= BB_W'(16);
			head_q        <= '0;
			head_valid_q  <= 1'b1;
			fc_q          <= BC_W'(LIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_COUNT: block_count_q <= cfg_data[BC_W-1:0];
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BB_W-1:0];
				default: ;
			endcase
			head_q       <= '0;
			head_valid_q <= 1'b1;
			fc_q         <= cfg_ec;
		end else if (exec) begin
			if (req_s1 == REQ_ALLOC) begin
				// pop
				if (alloc_ok) begin
					head_q       <= link;
					fc_q         <= fc_q - BC_W'(1);
					head_valid_q <= (fc_q != BC_W'(1));
				end
			end else if (free_ok) begin
				// push, or rechain once every block is back
				if (release_hit) begin
					head_q       <= '0;
					head_valid_q <= 1'b1;
					fc_q         <= ec;
				end else begin
					head_q       <= idx_s1;
					head_valid_q <= 1'b1;
					fc_q         <= fc_inc;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (exec) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (exec) begin
			granted_q      <= (req_s1 == REQ_ALLOC) && alloc_ok;
			given_index_q  <= ((req_s1 == REQ_ALLOC) && alloc_ok) ? head_q : '0;
			given_offset_q <= ((req_s1 == REQ_ALLOC) && alloc_ok) ? prod[OFS_W-1:0] : '0;
			exhausted_q    <= (req_s1 == REQ_ALLOC) && !alloc_ok;
			released_q     <= release_hit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, released_q, exhausted_q, given_offset_q, given_index_q, granted_q};

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed block free-list allocator. Allocate and
// free requests go in on the input stream. A behavioral copy of the free list
// (link store, head and free counter) predicts every reply. Replies are
// compared field by field, in order. Directed tests cover register extremes,
// empty-list allocates, out-of-range and double frees, and bucket release.
// A long backpressure hold follows. Random traffic then alternates fill and
// drain sequences over many bucket settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fbfl_pkg::*;

	localparam int MAX_BLOCKS    = 256;
	localparam int CHAIN_LIMIT   = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
	localparam int RANDOM_ITEMS  = 1170;
	localparam int QUIET_ITEMS   = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 5000;

	// one reply, laid out as in m_tdata[30:0]
	typedef struct packed {
		logic             released;
		logic             exhausted;
		logic [OFS_W-1:0] offset;
		logic [IDX_W-1:0] index;
		logic             granted;
	} alloc_reply_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;  // [7:0] block_index
	logic             s_tuser   = 1'b0;  // [0] req_type
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;  // [0] granted, [8:1] given_index, [28:9] given_offset,
	                            // [29] exhausted, [30] bucket_released, [31] zero
	logic             cfg_we    = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data  = '0;

	// bucket copy used for prediction
	logic [IDX_W-1:0] link_mem [256];
	logic [IDX_W-1:0] head_at;
	bit               head_ok;
	int unsigned      free_blocks;
	logic [BC_W-1:0]  count_reg;
	logic [BB_W-1:0]  bytes_reg;

	alloc_reply_t     predicted_replies [$];
	logic [IDX_W-1:0] held_blocks [$];
	bit               last_exhausted;
	int unsigned      served_items;
	int unsigned      mismatches;
	int unsigned      stall_cycles;
	bit               hold_request;
	bit               quiet;

	fixed_block_free_list_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	function automatic int unsigned usable_blocks();
		int unsigned c;
		c = count_reg;
		if (c < 1) c = 1;
		if (c > CHAIN_LIMIT) c = CHAIN_LIMIT;
		return c;
	endfunction

	// fresh chain 0,1,2,... with every block free
	function automatic void rebuild_chain();
		for (int i = 0; i < 256; i++) link_mem[i] = IDX_W'(i + 1);
		head_at     = '0;
		head_ok     = 1'b1;
		free_blocks = usable_blocks();
	endfunction

	function automatic alloc_reply_t predict_reply(logic kind, logic [IDX_W-1:0] idx);
		alloc_reply_t     r;
		int unsigned      lim;
		logic [IDX_W-1:0] got;
		logic [31:0]      prod;
		r   = '0;
		lim = usable_blocks();
		if (kind == REQ_ALLOC) begin
			// pop the head unless the list is empty
			if (!head_ok || free_blocks == 0) begin
				r.exhausted = 1'b1;
				return r;
			end
			got       = head_at;
			prod      = 32'(got) * 32'(bytes_reg);
			r.granted = 1'b1;
			r.index   = got;
			r.offset  = prod[OFS_W-1:0];
			head_at   = link_mem[got];
			free_blocks--;
			head_ok   = (free_blocks != 0);
		end else if (idx < lim) begin
			// push; free count saturates, full bucket is released
			link_mem[idx] = head_ok ? head_at : '0;
			head_at       = idx;
			head_ok       = 1'b1;
			if (free_blocks < lim) free_blocks++;
			if (free_blocks >= lim) begin
				r.released = 1'b1;
				rebuild_chain();
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offer one request; returns at the edge where it is taken, valid still high
	task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx);
		alloc_reply_t r;
		bit           ignored;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= idx;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		ignored = (kind == REQ_FREE) && (idx >= usable_blocks());
		r = predict_reply(kind, idx);
		predicted_replies.push_back(r);
		if (!ignored) served_items++;
		last_exhausted = r.exhausted;
		// track which blocks the stimulus holds
		if (r.granted) held_blocks.push_back(r.index);
		if (kind == REQ_FREE && !ignored) begin
			for (int i = 0; i < held_blocks.size(); i++) begin
				if (held_blocks[i] == idx) begin
					held_blocks.delete(i);
					break;
				end
			end
		end
		if (r.released) held_blocks.delete();
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (predicted_replies.size() != 0) @(posedge clk);
	endtask

	// write only with the block idle
	task automatic write_register(input logic which, input logic [CFG_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == REG_BLOCK_COUNT) count_reg = value[BC_W-1:0];
		else bytes_reg = value[BB_W-1:0];
		rebuild_chain();
		held_blocks.delete();
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset settings: 256 blocks of 16 bytes
	task automatic test_default_chain();
		send_request(REQ_ALLOC, 8'hFF);
		send_request(REQ_FREE, 8'd255);
		send_request(REQ_ALLOC, 8'h00);
	endtask

	task automatic test_offset_extremes();
		// largest size: offset of block 255 is truncated
		write_register(REG_BLOCK_BYTES, 13'h1FFF);
		send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_FREE, 8'd255);
		send_request(REQ_ALLOC, 8'h00);
		write_register(REG_BLOCK_BYTES, 13'd0);
		send_request(REQ_ALLOC, 8'h00);
		write_register(REG_BLOCK_BYTES, 13'd4096);
		send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_ALLOC, 8'h00);
		write_register(REG_BLOCK_BYTES, 13'd1);
		send_request(REQ_ALLOC, 8'h00);
	endtask

	task automatic test_count_limits();
		// zero count acts as one block
		write_register(REG_BLOCK_COUNT, 13'd0);
		send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_FREE, 8'd255);
		send_request(REQ_FREE, 8'd0);
		// count above the limit clamps; free with all blocks free releases
		write_register(REG_BLOCK_COUNT, 13'h1FFF);
		send_request(REQ_FREE, 8'd0);
		// exhaust four blocks, double free, then release
		write_register(REG_BLOCK_COUNT, 13'd4);
		repeat (5) send_request(REQ_ALLOC, 8'h00);
		send_request(REQ_FREE, 8'd3);
		send_request(REQ_FREE, 8'd3);
		send_request(REQ_FREE, 8'd0);
		send_request(REQ_FREE, 8'd1);
		// a write in the middle of use rebuilds the chain
		send_request(REQ_ALLOC, 8'h00);
		write_register(REG_BLOCK_COUNT, 13'd256);
		send_request(REQ_ALLOC, 8'h00);
	endtask

	// long sink hold with the source still offering, then a full drain
	task automatic test_backpressure();
		write_register(REG_BLOCK_BYTES, 13'($urandom_range(1, 8191)));
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_request((i % 3 == 2) ? REQ_FREE : REQ_ALLOC, 8'($urandom_range(0, 40)));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int unsigned      start;
		int unsigned      phase_len;
		int unsigned      lim;
		int               pick;
		bit               filling;
		bit               first;
		logic             kind;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] value;
		start = served_items;
		first = 1'b1;
		while (served_items - start < RANDOM_ITEMS) begin
			// bucket setting for this phase, mostly small
			pick = $urandom_range(0, 19);
			if (first) value = 13'd256;
			else if (pick == 0) value = ($urandom_range(0, 1) == 0) ? 13'd256 : 13'($urandom);
			else if (pick == 1) value = 13'd0;
			else if (pick < 6) value = 13'($urandom_range(17, 80));
			else value = 13'($urandom_range(1, 16));
			first = 1'b0;
			write_register(REG_BLOCK_COUNT, value);
			pick = $urandom_range(0, 9);
			case (pick)
				0: value = 13'd0;
				1: value = 13'h1FFF;
				2: value = 13'd4096;
				3: value = 13'd1;
				default: value = 13'($urandom_range(1, 8191));
			endcase
			write_register(REG_BLOCK_BYTES, value);
			lim = usable_blocks();
			phase_len = (lim > 128) ? 700 : (lim > 16) ? 120 : 50;
			filling = 1'b1;
			for (int n = 0; n < phase_len && served_items - start < RANDOM_ITEMS; n++) begin
				quiet = (served_items - start + QUIET_ITEMS >= RANDOM_ITEMS);
				pick = $urandom_range(0, 99);
				kind = (filling ? (pick < 85) : (pick >= 85)) ? REQ_ALLOC : REQ_FREE;
				idx  = 8'($urandom);
				if (kind == REQ_FREE && held_blocks.size() != 0 && $urandom_range(0, 9) != 0)
					idx = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
				sender_gap();
				send_request(kind, idx);
				// turn around at the empty and the full list
				if (last_exhausted) filling = 1'b0;
				else if (held_blocks.size() == 0) filling = 1'b1;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// result sink: random stalls and the long hold
	// ------------------------------------------------------------------------
	initial begin : reply_sink
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (arst_n && !quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 17);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// compare each reply taken at the coming edge with the oldest prediction
	always @(negedge clk) begin : reply_check
		alloc_reply_t got;
		alloc_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[30:0];
			if (predicted_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none actual %0h", $time, m_tdata);
				mismatches++;
			end else begin
				want = predicted_replies.pop_front();
				check_field("granted", 32'(want.granted), 32'(got.granted));
				check_field("given_index", 32'(want.index), 32'(got.index));
				check_field("given_offset", 32'(want.offset), 32'(got.offset));
				check_field("exhausted", 32'(want.exhausted), 32'(got.exhausted));
				check_field("bucket_released", 32'(want.released), 32'(got.released));
				check_field("pad bit", 32'(0), 32'(m_tdata[31]));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		count_reg = 9'd256;
		bytes_reg = 13'd16;
		rebuild_chain();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_chain();
		test_offset_extremes();
		test_count_limits();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_replies.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
